>>> src/lru_recency_list_macros.svh
// assertion macros for the lru recency list block
// used by the top level only; no other dependencies
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH

// same-cycle implication
`define LRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lrl_pkg.sv
// shared types and constants for the lru recency list block
// no dependencies; used by lrl_link_ram, lrl_engine and lru_recency_list
`timescale 1ns / 1ps
`default_nettype none

package lrl_pkg;

  // default id range
  localparam int NUM_IDS_DEF = 256;

  // fixed field widths
  localparam int ID_W   = 8;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 9;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

  // capacity register
  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;
  localparam logic [CNT_W-1:0] CNT_MAX   = 9'd256;

  // result beat packing
  localparam int RES_W      = 2 + ID_W + CNT_W;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

  // result handed from the engine to the output register
  typedef struct packed {
    logic             was_present;
    logic             evicted;
    logic [ID_W-1:0]  evicted_id;
    logic [CNT_W-1:0] occupancy;
  } res_t;

endpackage

`default_nettype wire

>>> src/lrl_link_ram.sv
// one link table: simple dual port ram, one write and one registered read
// parameter default from lrl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrl_link_ram #(
  parameter int DEPTH = lrl_pkg::NUM_IDS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/lrl_engine.sv
// sequencer for the recency list: membership bits, head, tail, count and
// the one-write-per-table link update steps; uses lrl_pkg and two link rams
`timescale 1ns / 1ps
`default_nettype none

module lrl_engine #(
  parameter int NUM_IDS = lrl_pkg::NUM_IDS_DEF,
  localparam int LINK_W = $clog2(NUM_IDS)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // item in
  input  wire logic                      start,
  input  wire logic [lrl_pkg::KIND_W-1:0] kind,
  input  wire logic [lrl_pkg::ID_W-1:0]   entry_id,
  input  wire logic [lrl_pkg::CNT_W-1:0]  capacity,
  output logic                           idle,
  // result out
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output lrl_pkg::res_t                  res,
  // prev link table
  output logic                           prev_we,
  output logic      [LINK_W-1:0]         prev_waddr,
  output logic      [LINK_W-1:0]         prev_wdata,
  output logic      [LINK_W-1:0]         prev_raddr,
  input  wire logic [LINK_W-1:0]         prev_rdata,
  // next link table
  output logic                           next_we,
  output logic      [LINK_W-1:0]         next_waddr,
  output logic      [LINK_W-1:0]         next_wdata,
  output logic      [LINK_W-1:0]         next_raddr,
  input  wire logic [LINK_W-1:0]         next_rdata
);

  localparam int CW = lrl_pkg::CNT_W;
  localparam int XW = (LINK_W > lrl_pkg::ID_W) ? LINK_W : lrl_pkg::ID_W;
  // ids above the input field range never enter the list
  localparam int PRES_N = (NUM_IDS < 256) ? NUM_IDS : 256;
  localparam int PRES_W = $clog2(PRES_N);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UNLINK = 3'd1;
  localparam logic [2:0] ST_LINK1  = 3'd2;
  localparam logic [2:0] ST_LINK2  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state;
  logic [PRES_N-1:0] present;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] tail;
  logic [CW-1:0]     count;

  // per-item payload
  logic              front_q;
  logic [LINK_W-1:0] id_q;
  logic              touch_q;
  logic [LINK_W-1:0] target_q;
  logic              was_q;
  logic              evict_q;
  logic [LINK_W-1:0] victim_q;

  // decode of the incoming beat
  logic [XW-1:0]     id_x;
  logic [LINK_W-1:0] id_l;
  logic              id_ok;
  logic              touch;
  logic              pres;
  logic [CW-1:0]     cap_eff;
  logic              need_drop;
  logic              do_unlink;
  logic [LINK_W-1:0] target;

  assign id_x    = XW'(entry_id);
  assign id_l    = id_x[LINK_W-1:0];
  assign id_ok   = {1'b0, id_x} < (XW + 1)'(NUM_IDS);
  assign touch   = ((kind == lrl_pkg::KIND_FRONT) || (kind == lrl_pkg::KIND_BACK)) && id_ok;
  assign pres    = touch && present[id_x[PRES_W-1:0]];
  assign cap_eff = (capacity == '0) ? CW'(1) : capacity;

  always_comb begin
    if (kind == lrl_pkg::KIND_EVICT) begin
      need_drop = (count != '0);
    end else begin
      need_drop = touch && !pres && (count >= cap_eff);
    end
  end

  assign do_unlink = pres || need_drop;
  assign target    = pres ? id_l : tail;

  // neighbour read of the entry to unlink, issued with the accept
  assign prev_raddr = target;
  assign next_raddr = target;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      present <= '0;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (need_drop) begin
              present[tail[PRES_W-1:0]] <= 1'b0;
            end
            if (touch && !pres) begin
              present[id_x[PRES_W-1:0]] <= 1'b1;
            end
            if (do_unlink) begin
              state <= ST_UNLINK;
            end else if (touch) begin
              state <= ST_LINK1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_UNLINK: begin
          if (count > CW'(1)) begin
            if (target_q == head) begin
              head <= next_rdata;
            end
            if (target_q == tail) begin
              tail <= prev_rdata;
            end
          end
          count <= count - CW'(1);
          state <= touch_q ? ST_LINK1 : ST_DONE;
        end
        ST_LINK1: begin
          if (count == '0) begin
            if (front_q) begin
              tail <= id_q;
            end else begin
              head <= id_q;
            end
          end
          state <= ST_LINK2;
        end
        ST_LINK2: begin
          if (front_q) begin
            head <= id_q;
          end else begin
            tail <= id_q;
          end
          count <= count + CW'(1);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item payload, latched at accept
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      front_q  <= (kind == lrl_pkg::KIND_FRONT);
      id_q     <= id_l;
      touch_q  <= touch;
      target_q <= target;
      was_q    <= pres;
      evict_q  <= need_drop;
      victim_q <= tail;
    end
  end

  // one link write per table per step
  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    unique case (state)
      ST_UNLINK: begin
        if (count > CW'(1)) begin
          // bridge over the removed entry
          if (target_q != head) begin
            next_we    = 1'b1;
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
          end
          if (target_q != tail) begin
            prev_we    = 1'b1;
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
          end
        end
      end
      ST_LINK1: begin
        if (count != '0) begin
          if (front_q) begin
            next_we    = 1'b1;
            next_waddr = id_q;
            next_wdata = head;
            prev_we    = 1'b1;
            prev_waddr = head;
            prev_wdata = id_q;
          end else begin
            prev_we    = 1'b1;
            prev_waddr = id_q;
            prev_wdata = tail;
            next_we    = 1'b1;
            next_waddr = tail;
            next_wdata = id_q;
          end
        end
      end
      ST_LINK2: begin
        // an end entry points at itself
        if (front_q) begin
          prev_we    = 1'b1;
          prev_waddr = id_q;
          prev_wdata = id_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = id_q;
          next_wdata = id_q;
        end
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // status and result
  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.was_present = was_q;
    res.evicted     = evict_q;
    res.evicted_id  = evict_q ? lrl_pkg::ID_W'(victim_q) : '0;
    res.occupancy   = count;
  end

endmodule

`default_nettype wire

>>> src/lru_recency_list.sv
// lru recency list: doubly linked recency order over entry ids in two link rams.
// one item at a time; s_tready is high only while the sequencer is idle.
// ram steps per item after accept: unlink, link1 and link2 for a touch of a present id
// or an insert that evicts, link1 and link2 for a plain insert, unlink for evict tail,
// none for an ignored item; each item ends in done, which the output reg frees.
// sync reset clears membership bits, head, tail and count at once; links need no clear.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_recency_list_macros.svh"

module lru_recency_list #(
  parameter int NUM_IDS = lrl_pkg::NUM_IDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write: capacity
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lrl_pkg::CNT_W-1:0]     cfg_data,
  // item in
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lrl_pkg::ID_W-1:0]      s_tdata,   // [7:0] entry_id
  input  wire logic [lrl_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
  // result out
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lrl_pkg::OUT_DATA_W-1:0]     m_tdata    // [0] was_present, [1] evicted,
                                                        // [9:2] evicted_id, [18:10] occupancy
);

  localparam int LINK_W = $clog2(NUM_IDS);

  logic [lrl_pkg::CNT_W-1:0] capacity;
  logic                      eng_idle;
  logic                      eng_res_valid;
  logic                      eng_res_ready;
  lrl_pkg::res_t             eng_res;
  logic                      out_valid;
  lrl_pkg::res_t             out_res;

  logic              prev_we;
  logic [LINK_W-1:0] prev_waddr;
  logic [LINK_W-1:0] prev_wdata;
  logic [LINK_W-1:0] prev_raddr;
  logic [LINK_W-1:0] prev_rdata;
  logic              next_we;
  logic [LINK_W-1:0] next_waddr;
  logic [LINK_W-1:0] next_wdata;
  logic [LINK_W-1:0] next_raddr;
  logic [LINK_W-1:0] next_rdata;

  // capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrl_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // sequencer
  assign s_tready = eng_idle;

  lrl_engine #(
    .NUM_IDS (NUM_IDS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (s_tvalid),
    .kind       (s_tuser),
    .entry_id   (s_tdata),
    .capacity   (capacity),
    .idle       (eng_idle),
    .res_valid  (eng_res_valid),
    .res_ready  (eng_res_ready),
    .res        (eng_res),
    .prev_we    (prev_we),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .prev_raddr (prev_raddr),
    .prev_rdata (prev_rdata),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .next_raddr (next_raddr),
    .next_rdata (next_rdata)
  );

  // link tables
  lrl_link_ram #(
    .DEPTH (NUM_IDS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  lrl_link_ram #(
    .DEPTH (NUM_IDS)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  // output register
  assign eng_res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_res <= eng_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{lrl_pkg::OUT_PAD_W{1'b0}}, out_res.occupancy, out_res.evicted_id,
                     out_res.evicted, out_res.was_present};

  // checks
  `LRL_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready,
                   "accepted a beat while an item was in progress")
  `LRL_ASSERT_NEXT(a_engine_result_holds, clk, rst, eng_res_valid && !eng_res_ready,
                   eng_res_valid && $stable(eng_res), "engine result changed while stalled")
  `LRL_ASSERT_NOW(a_result_sane, clk, rst, m_tvalid,
                  !(out_res.was_present && out_res.evicted) &&
                  (out_res.occupancy <= lrl_pkg::CNT_MAX),
                  "hit with eviction or occupancy out of range")

endmodule

`default_nettype wire
